>>> sv/assert_macros.svh
// Assertion macros shared by the timer bank RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define STB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("timer bank assertion failed");
`define STB_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("timer bank assertion failed");
`else
`define STB_ASSERT(lbl, prop)
`define STB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> sv/stb_pkg.sv
// Types and constants of the timer bank: timer modes, commands, sequencer states.
// No dependencies.
package stb_pkg;

	localparam int MAX_REPORTS = 8;
	localparam int REP_W       = $clog2(MAX_REPORTS + 1);

	typedef enum logic [1:0] {
		MODE_STOP  = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_START = 2'd2,
		MODE_RESET = 2'd3
	} mode_t;

	typedef enum logic {
		CMD_TICK  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EXEC,
		ST_FLUSH,
		ST_WRD,
		ST_WWR
	} state_t;

endpackage

>>> sv/stb_if.sv
// Valid/ready channel interfaces of the timer bank: command words in, reports out.
// No dependencies.
interface stb_item_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [2:0]  timer_index;
	logic [15:0] load_value;
	logic        restart_flag;
	logic [1:0]  write_mode;
	logic        notify_enable;

	modport source (output valid, command, timer_index, load_value, restart_flag,
		write_mode, notify_enable, input ready);
	modport sink (input valid, command, timer_index, load_value, restart_flag,
		write_mode, notify_enable, output ready);
endinterface

interface stb_report_if;
	logic       valid;
	logic       ready;
	logic [2:0] fired_timer;
	logic       last;

	modport source (output valid, fired_timer, last, input ready);
	modport sink (input valid, fired_timer, last, output ready);
endinterface

>>> sv/stb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stb_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/software_timer_bank.sv
// Timer bank top level: sequencer, shared decrementer and report register.
// Depends on stb_pkg, stb_if, stb_ram and assert_macros.svh.
//
// Usage:
//   item channel (valid/ready) takes one word: a write of one timer entry or a tick.
//   report channel (valid/ready) gives one word per expiry report of a tick, with
//   last set on the final report of that tick; a tick with no reports gives none.
//   A write reads the entry, then merges and writes it back; a write to an index
//   beyond the bank changes nothing.
//   A tick walks the bank: each entry is read from the entry RAM, then updated by the
//   one shared decrementer and written back, one entry at a time.
//   The report register first loads when the second reporting entry is updated, or
//   in the flush state after the walk; item.ready is low while a word is in progress.
//   A stalled report sink holds the walk at the next reporting entry and at the end.
//   Reset puts every timer in stop mode with zero count, reload and flags
//   (per-entry valid bits, no clearing pass); the block is ready at once.
`include "assert_macros.svh"

module software_timer_bank import stb_pkg::*; #(
	parameter int NUM_TIMERS  = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	stb_item_if.sink        item,
	stb_report_if.source    report
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	typedef struct packed {
		mode_t                  mode;
		logic [COUNT_WIDTH-1:0] count;
		logic [COUNT_WIDTH-1:0] reload;
		logic                   restart;
		logic                   notify;
	} entry_t;

	localparam int EW = $bits(entry_t);

	state_t                 state_q, state_d;
	logic [IW-1:0]          idx_q;
	logic [REP_W-1:0]       rep_cnt_q;
	logic                   pend_q;
	logic [2:0]             pend_idx_q;
	logic                   out_valid_q;
	logic [2:0]             fired_q;
	logic                   last_q;
	logic [IW-1:0]          wr_idx_q;
	logic [COUNT_WIDTH-1:0] wr_load_q;
	logic                   wr_restart_q;
	logic                   wr_notify_q;
	mode_t                  wr_mode_q;
	logic [NUM_TIMERS-1:0]  vld_q;
	logic                   vld_rd_q;

	logic [EW-1:0]          ram_rdata;
	logic [EW-1:0]          ram_wdata;
	logic                   ram_we, ram_re;
	logic [IW-1:0]          ram_waddr, ram_raddr;

	entry_t                 cur, nxt;
	logic                   expired, fire, out_free, idx_last, advance, load_out;
	logic                   acc, win_ok;
	logic [COUNT_WIDTH-1:0] dec_in, dec_out;
	logic [6:0]             win, idx_w;
	logic [31:0]            load_w;

	stb_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_TIMERS)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cur      = vld_rd_q ? entry_t'(ram_rdata) : '0;
	assign win      = 7'(item.timer_index);
	assign win_ok   = win < 7'(NUM_TIMERS);
	assign load_w   = 32'(item.load_value);
	assign idx_w    = 7'(idx_q);
	assign idx_last = idx_q == IW'(NUM_TIMERS - 1);
	assign out_free = !out_valid_q || report.ready;
	assign acc      = item.valid && item.ready;

	// shared decrementer and entry update
	assign expired = (cur.mode == MODE_RUN) && (cur.count == '0);
	assign dec_in  = (expired && cur.restart) ? cur.reload : cur.count;
	assign dec_out = dec_in - COUNT_WIDTH'(1);
	assign fire    = expired && cur.notify && (rep_cnt_q < REP_W'(MAX_REPORTS));

	always_comb begin
		nxt = cur;
		case (cur.mode)
			MODE_RUN: begin
				nxt.count = dec_out;
				if (expired && !cur.restart) begin
					nxt.mode = MODE_STOP;
				end
			end
			MODE_START: begin
				nxt.count = cur.reload;
				nxt.mode  = MODE_RUN;
			end
			MODE_RESET: nxt.mode = MODE_START;
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (item.command == CMD_WRITE) begin
						state_d = win_ok ? ST_WRD : ST_IDLE;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			ST_RD: state_d = ST_EXEC;
			ST_EXEC: begin
				if (advance) begin
					state_d = idx_last ? ST_FLUSH : ST_RD;
				end
			end
			ST_FLUSH: begin
				if (!pend_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_WRD: state_d = ST_WWR;
			ST_WWR: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = idx_q;
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata  = nxt;
		advance    = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: item.ready = 1'b1;
			ST_RD: ram_re = 1'b1;
			ST_EXEC: begin
				advance  = !(fire && pend_q) || out_free;
				ram_we   = advance;
				load_out = advance && fire && pend_q;
			end
			ST_FLUSH: load_out = pend_q && out_free;
			ST_WRD: begin
				ram_re    = 1'b1;
				ram_raddr = wr_idx_q;
			end
			ST_WWR: begin
				ram_we    = 1'b1;
				ram_waddr = wr_idx_q;
				ram_wdata = {wr_mode_q, cur.count, wr_load_q, wr_restart_q, wr_notify_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			rep_cnt_q   <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
			vld_rd_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc && item.command == CMD_TICK) begin
				idx_q     <= '0;
				rep_cnt_q <= '0;
				pend_q    <= 1'b0;
			end else if (advance) begin
				if (!idx_last) begin
					idx_q <= idx_q + IW'(1);
				end
				if (fire) begin
					rep_cnt_q <= rep_cnt_q + REP_W'(1);
					pend_q    <= 1'b1;
				end
			end else if (load_out) begin
				pend_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (report.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				vld_rd_q <= vld_q[ram_raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			pend_idx_q <= idx_w[2:0];
		end
		if (load_out) begin
			fired_q <= pend_idx_q;
			last_q  <= state_q == ST_FLUSH;
		end
		if (acc) begin
			wr_idx_q     <= win[IW-1:0];
			wr_load_q    <= load_w[COUNT_WIDTH-1:0];
			wr_restart_q <= item.restart_flag;
			wr_notify_q  <= item.notify_enable;
			wr_mode_q    <= mode_t'(item.write_mode);
		end
	end

	assign report.valid       = out_valid_q;
	assign report.fired_timer = fired_q;
	assign report.last        = last_q;

	`STB_ASSERT(a_idle_no_pending, (state_q == ST_IDLE) |-> !pend_q)
	`STB_ASSERT(a_report_cap, rep_cnt_q <= REP_W'(MAX_REPORTS))
	`STB_ASSERT(a_load_when_free, load_out |-> out_free)
	`STB_ASSERT_ALWAYS(a_ram_one_access, !(ram_we && ram_re))

endmodule
